>>> rtl/idq_pkg.sv
// Shared types, constants and helpers of the integer deque with search.
`default_nettype none

package idq_pkg;

    // Ring geometry
    localparam int DEPTH = 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = CW + 1;
    localparam int VW    = 32;
    localparam int RW    = 3;

    // Request codes
    typedef enum logic [RW-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_FIND       = 3'd4,
        REQ_READ_ALL   = 3'd5
    } t_req;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_simple;
        logic start_walk;
        logic step;
        logic load_find;
        logic load_entry;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_walk;
        logic is_find;
        logic hit;
        logic at_last;
        logic out_last;
    } t_dp_status;

    // Ring position: base plus offset, wrapped once (offset never exceeds DEPTH)
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/idq_req_if.sv
// Request channel: request type and value with valid/ready.
`default_nettype none

interface idq_req_if;
    import idq_pkg::*;

    logic          valid;
    logic          ready;
    logic [RW-1:0] req_type;
    logic [VW-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/idq_rsp_if.sv
// Result channel: status fields and readout entry with valid/ready.
`default_nettype none

interface idq_rsp_if;
    import idq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [CW-1:0]        count;
    logic                 dropped;
    logic signed [VW-1:0] entry_value;
    logic                 entry_valid;
    logic                 last;

    modport source (output valid, output found, output count, output dropped,
                     output entry_value, output entry_valid, output last,
                     input ready);
    modport sink   (input valid, input found, input count, input dropped,
                     input entry_value, input entry_valid, input last,
                     output ready);
endinterface

`default_nettype wire

>>> rtl/idq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module idq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/idq_dp.sv
// Datapath: ring pointers, count, entry store, walk index and result register.
`default_nettype none

module idq_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [idq_pkg::RW-1:0]      i_req_type,
    input  wire logic [idq_pkg::VW-1:0]      i_value,
    input  wire idq_pkg::t_dp_cmd            i_cmd,
    output idq_pkg::t_dp_status              o_status,
    output logic                             o_found,
    output logic [idq_pkg::CW-1:0]           o_count,
    output logic                             o_dropped,
    output logic [idq_pkg::VW-1:0]           o_entry_value,
    output logic                             o_entry_valid,
    output logic                             o_last
);
    import idq_pkg::*;

    logic [AW-1:0] r_front;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_idx;
    logic [VW-1:0] r_value;
    logic          r_is_find;
    logic          r_found;
    logic          r_dropped;
    logic [VW-1:0] r_entry_value;
    logic          r_entry_valid;
    logic          r_last;

    t_req          req;
    logic          full;
    logic          empty;
    logic          is_push;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [AW-1:0] back_pos;
    logic [CW-1:0] next_off;
    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [VW-1:0] rdata;

    // Decode and ring arithmetic
    assign req       = t_req'(i_req_type);
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign is_push   = (req == REQ_PUSH_FRONT) || (req == REQ_PUSH_BACK);
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : (r_front - AW'(1));
    assign front_inc = ring_add(r_front, CW'(1));
    assign back_pos  = ring_add(r_front, r_count);
    assign next_off  = CW'(r_idx) + CW'(1);

    // Store ports: pushes write, walk reads one entry ahead
    assign we    = i_cmd.load_simple && is_push && !full;
    assign waddr = (req == REQ_PUSH_FRONT) ? front_dec : back_pos;
    assign raddr = i_cmd.start_walk ? r_front : ring_add(r_front, next_off);

    idq_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Status to the controller
    assign o_status.in_walk  = ((req == REQ_FIND) || (req == REQ_READ_ALL)) && !empty;
    assign o_status.is_find  = r_is_find;
    assign o_status.hit      = (rdata == r_value);
    assign o_status.at_last  = (next_off == r_count);
    assign o_status.out_last = r_last;

    // Pointers, count and walk index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.load_simple) begin
                unique case (req)
                    REQ_PUSH_FRONT: begin
                        if (!full) begin
                            r_front <= front_dec;
                            r_count <= r_count + CW'(1);
                        end
                    end
                    REQ_PUSH_BACK: begin
                        if (!full) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    REQ_POP_FRONT: begin
                        if (!empty) begin
                            r_front <= front_inc;
                            r_count <= r_count - CW'(1);
                        end
                    end
                    REQ_POP_BACK: begin
                        if (!empty) begin
                            r_count <= r_count - CW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.start_walk) begin
                r_idx <= '0;
            end else if (i_cmd.step) begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    // Latched request and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_walk) begin
            r_value   <= i_value;
            r_is_find <= (req == REQ_FIND);
        end
        if (i_cmd.load_simple) begin
            r_found       <= 1'b0;
            r_dropped     <= is_push && full;
            r_entry_value <= '0;
            r_entry_valid <= 1'b0;
            r_last        <= 1'b1;
        end else if (i_cmd.load_find) begin
            r_found       <= o_status.hit;
            r_dropped     <= 1'b0;
            r_entry_value <= '0;
            r_entry_valid <= 1'b0;
            r_last        <= 1'b1;
        end else if (i_cmd.load_entry) begin
            r_found       <= 1'b0;
            r_dropped     <= 1'b0;
            r_entry_value <= rdata;
            r_entry_valid <= 1'b1;
            r_last        <= o_status.at_last;
        end
    end

    assign o_found       = r_found;
    assign o_count       = r_count;
    assign o_dropped     = r_dropped;
    assign o_entry_value = r_entry_value;
    assign o_entry_valid = r_entry_valid;
    assign o_last        = r_last;

endmodule

`default_nettype wire

>>> rtl/idq_ctrl.sv
// Controller: request sequencing, entry walk and result handshake.
`default_nettype none

module idq_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire idq_pkg::t_dp_status  i_status,
    output idq_pkg::t_dp_cmd          o_cmd
);
    import idq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_acc;
    logic   out_acc;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = o_out_valid && i_out_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_status.in_walk) begin
                        o_cmd.start_walk = 1'b1;
                        n_state          = ST_WALK;
                    end else begin
                        o_cmd.load_simple = 1'b1;
                        n_state           = ST_OUT;
                    end
                end
            end
            ST_WALK: begin
                if (i_status.is_find) begin
                    if (i_status.hit || i_status.at_last) begin
                        o_cmd.load_find = 1'b1;
                        n_state         = ST_OUT;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end else begin
                    o_cmd.load_entry = 1'b1;
                    n_state          = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    if (i_status.out_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        // next readout entry: its read is issued this cycle
                        o_cmd.step = 1'b1;
                        n_state    = ST_WALK;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> rtl/int_deque_with_search_unit.sv
// Push, pop and unused requests give their one result in the cycle after acceptance.
// Find: the walk stops at the first hit or the last entry, one store read per cycle.
// Readout: each entry is read, then registered; the next read follows its acceptance.
// One item at a time: the next item is taken once the last result of the previous one goes.
// Reset (synchronous, active low) empties the ring; the entry store itself is not cleared.
`default_nettype none

module int_deque_with_search_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    idq_req_if.sink    i_req,
    idq_rsp_if.source  o_rsp
);
    import idq_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    idq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    idq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_type    (i_req.req_type),
        .i_value       (i_req.value),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_found       (o_rsp.found),
        .o_count       (o_rsp.count),
        .o_dropped     (o_rsp.dropped),
        .o_entry_value (o_rsp.entry_value),
        .o_entry_valid (o_rsp.entry_valid),
        .o_last        (o_rsp.last)
    );

endmodule

`default_nettype wire
